// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property with the reset held low masking it.
`define IRPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds while reset is applied.
`define IRPM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/irpm_pkg.sv =====
// Package with the sizes, codes and shared types of the pulse template matcher.
package irpm_pkg;

  // Template count and depth are powers of two so that the store address is {slot, position}.
  localparam int TEMPLATES     = 16;
  localparam int MAX_PULSES    = 64;
  localparam int DURATION_BITS = 16;

  localparam int SLOT_W  = $clog2(TEMPLATES);
  localparam int POS_W   = $clog2(MAX_PULSES);
  localparam int ADDR_W  = SLOT_W + POS_W;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int LEN_W   = 7;
  localparam int SUM_W   = 17;
  localparam int TOL_W   = 10;
  localparam int MODE_W  = 2;
  localparam int SCORE_W = 16;

  localparam logic [MODE_W-1:0] MODE_WORD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;

  localparam logic CFG_TOLERANCE  = 1'b0;
  localparam logic CFG_MIN_PULSES = 1'b1;

  localparam logic [TOL_W-1:0]   TOL_RESET  = 10'd100;
  localparam logic [LEN_W-1:0]   MINP_RESET = 7'd5;
  localparam logic [SUM_W-1:0]   SUM_MAX    = 17'h1FFFF;
  localparam logic [SCORE_W-1:0] SCORE_TOP  = 16'hFFFF;

  typedef logic [DURATION_BITS-1:0] dur_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [LEN_W-1:0]         len_t;

  typedef enum logic {ALU_ACC, ALU_MUL} alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    dur_t             pulse;
    dur_t             ref_word;
    sum_t             sum;
    len_t             seen;
    len_t             tlen;
    logic [TOL_W-1:0] tol;
  } alu_in_t;

endpackage

// ===== rtl/irpm_alu.sv =====
// Shared arithmetic unit: saturating absolute-difference accumulate or tolerance bound.
module irpm_alu import irpm_pkg::*; (
  input  alu_in_t ai,
  output sum_t    res
);

  dur_t                 diff;
  logic [SUM_W:0]       acc;
  len_t                 overlap;

  always_comb begin
    diff    = (ai.pulse > ai.ref_word) ? (ai.pulse - ai.ref_word) : (ai.ref_word - ai.pulse);
    acc     = {1'b0, ai.sum} + (SUM_W + 1)'(diff);
    overlap = (ai.seen < ai.tlen) ? ai.seen : ai.tlen;
    case (ai.op)
      ALU_ACC: res = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      ALU_MUL: res = SUM_W'(overlap) * SUM_W'(ai.tol);
      default: res = '0;
    endcase
  end

endmodule

// ===== rtl/irpm_store.sv =====
// Template word memory with one write port and one registered read port.
module irpm_store import irpm_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  dur_t              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output dur_t              rdata
);

  dur_t mem [TEMPLATES*MAX_PULSES];
  dur_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ir_pulse_template_matcher_top.sv =====
// Top level of the infrared pulse-train template matcher.
//
// Input stream: in_tuser carries the item kind (template word, template length
// or received pulse), in_tlast marks the last pulse of a train, in_tdata the rest.
// A load transaction is taken without leaving the idle state. A pulse
// transaction walks all templates through one shared accumulate unit, fed by
// the template memory's single read port; no further item is taken until the
// walk is done. A last pulse then walks the templates again through the same
// unit to find the best match, and one result transaction appears on the
// output stream; other items give no result.
// The result sits in an output register, so input transactions are taken while
// it waits. If the receiver still stalls when the next train ends, the block
// holds the finished search and stops taking input until the output frees up.
// Reset (synchronous, active low) restores the control registers, clears template
// lengths, sums and the pulse count; template words stay undefined until written.
// Configuration writes are taken at any cycle through cfg_we.
module ir_pulse_template_matcher_top import irpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] template_slot, [9:4] template_position, [25:10] template_word,
  // [32:26] template_length, [48:33] pulse_duration, [55:49] zero
  input  logic [55:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] matched_slot, [19:4] match_score, [23:20] zero
  output logic [23:0] out_tdata,
  // [0] match_found
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVAL, S_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  v_r, v_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  dur_t                  pulse_r, pulse_nxt;
  logic                  last_r, last_nxt;
  len_t                  seen_r, seen_nxt;
  len_t                  tl_r, tl_nxt;
  sum_t                  prod_r, prod_nxt;
  logic                  best_found_r, best_found_nxt;
  logic [SLOT_W-1:0]     best_slot_r, best_slot_nxt;
  logic [SCORE_W-1:0]    best_score_r, best_score_nxt;
  logic [TOL_W-1:0]      tol_r, tol_nxt;
  len_t                  minp_r, minp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [SCORE_W-1:0]    out_score_r, out_score_nxt;
  sum_t                  sums_r [TEMPLATES];
  sum_t                  sums_nxt [TEMPLATES];
  len_t                  lens_r [TEMPLATES];
  len_t                  lens_nxt [TEMPLATES];

  logic [MODE_W-1:0]     in_mode;
  logic [3:0]            in_slot;
  logic [5:0]            in_pos;
  dur_t                  in_word;
  len_t                  in_len;
  dur_t                  in_pulse;
  logic                  in_acc;
  logic                  st_we;
  logic                  st_re;
  logic [ADDR_W-1:0]     st_waddr;
  logic [ADDR_W-1:0]     st_raddr;
  dur_t                  st_rdata;
  alu_in_t               alu_in;
  sum_t                  alu_res;
  sum_t                  cur_sum;
  logic [SCORE_W-1:0]    cur_score;
  logic                  phase_done;

  assign in_mode  = in_tuser;
  assign in_slot  = in_tdata[3:0];
  assign in_pos   = in_tdata[9:4];
  assign in_word  = in_tdata[25:10];
  assign in_len   = in_tdata[32:26];
  assign in_pulse = in_tdata[48:33];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign st_we    = in_acc && (in_mode == MODE_WORD) && (32'(in_slot) < TEMPLATES)
                    && (32'(in_pos) < MAX_PULSES);
  assign st_waddr = {in_slot[SLOT_W-1:0], in_pos[POS_W-1:0]};
  assign st_re    = (state_r == S_SCAN) && !cnt_r[CNT_W-1];
  assign st_raddr = {cnt_r[SLOT_W-1:0], seen_r[POS_W-1:0]};

  irpm_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_word),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign cur_sum   = sums_r[idx_r];
  assign cur_score = SCORE_TOP - cur_sum[SCORE_W-1:0];

  always_comb begin
    alu_in.op       = (state_r == S_EVAL) ? ALU_MUL : ALU_ACC;
    alu_in.pulse    = pulse_r;
    alu_in.ref_word = st_rdata;
    alu_in.sum      = cur_sum;
    alu_in.seen     = seen_r;
    alu_in.tlen     = lens_r[cnt_r[SLOT_W-1:0]];
    alu_in.tol      = tol_r;
  end

  irpm_alu u_alu (
    .ai  (alu_in),
    .res (alu_res)
  );

  // Both walks end once the counter has passed the last template and stage two is empty.
  assign phase_done = cnt_r[CNT_W-1] && !v_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    v_nxt          = 1'b0;
    idx_nxt        = idx_r;
    pulse_nxt      = pulse_r;
    last_nxt       = last_r;
    seen_nxt       = seen_r;
    tl_nxt         = tl_r;
    prod_nxt       = prod_r;
    best_found_nxt = best_found_r;
    best_slot_nxt  = best_slot_r;
    best_score_nxt = best_score_r;
    tol_nxt        = tol_r;
    minp_nxt       = minp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    out_score_nxt  = out_score_r;
    sums_nxt       = sums_r;
    lens_nxt       = lens_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE:  tol_nxt  = cfg_wdata;
        CFG_MIN_PULSES: minp_nxt = cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end

    // Stage one of either walk: fetch the length, and the word or the bound.
    if ((state_r == S_SCAN || state_r == S_EVAL) && !cnt_r[CNT_W-1]) begin
      tl_nxt   = lens_r[cnt_r[SLOT_W-1:0]];
      prod_nxt = alu_res;
      idx_nxt  = cnt_r[SLOT_W-1:0];
      v_nxt    = 1'b1;
      cnt_nxt  = cnt_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_LEN: begin
              if (32'(in_slot) < TEMPLATES) begin
                lens_nxt[in_slot[SLOT_W-1:0]] =
                  (in_len > LEN_W'(MAX_PULSES)) ? LEN_W'(MAX_PULSES) : in_len;
              end
            end
            MODE_PULSE: begin
              pulse_nxt      = in_pulse;
              last_nxt       = in_tlast;
              cnt_nxt        = '0;
              best_found_nxt = 1'b0;
              best_slot_nxt  = '0;
              best_score_nxt = '0;
              if (seen_r < LEN_W'(MAX_PULSES)) begin
                state_nxt = S_SCAN;
              end else if (in_tlast) begin
                state_nxt = S_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (v_r && (seen_r < tl_r)) begin
          sums_nxt[idx_r] = alu_res;
        end
        if (phase_done) begin
          seen_nxt  = seen_r + LEN_W'(1);
          cnt_nxt   = '0;
          state_nxt = last_r ? S_EVAL : S_IDLE;
        end
      end
      S_EVAL: begin
        if (v_r && (tl_r != '0) && (cur_sum <= prod_r) && (cur_sum < SUM_W'(SCORE_TOP))
            && (cur_score > best_score_r)) begin
          best_found_nxt = 1'b1;
          best_slot_nxt  = idx_r;
          best_score_nxt = cur_score;
        end
        if (phase_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = best_found_r && (seen_r >= minp_r);
          out_slot_nxt  = out_found_nxt ? best_slot_r : '0;
          out_score_nxt = out_found_nxt ? best_score_r : '0;
          for (int t = 0; t < TEMPLATES; t++) begin
            sums_nxt[t] = '0;
          end
          seen_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      v_r         <= 1'b0;
      seen_r      <= '0;
      tol_r       <= TOL_RESET;
      minp_r      <= MINP_RESET;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TEMPLATES; t++) begin
        sums_r[t] <= '0;
        lens_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      v_r         <= v_nxt;
      seen_r      <= seen_nxt;
      tol_r       <= tol_nxt;
      minp_r      <= minp_nxt;
      out_valid_r <= out_valid_nxt;
      sums_r      <= sums_nxt;
      lens_r      <= lens_nxt;
    end
    idx_r        <= idx_nxt;
    pulse_r      <= pulse_nxt;
    last_r       <= last_nxt;
    tl_r         <= tl_nxt;
    prod_r       <= prod_nxt;
    best_found_r <= best_found_nxt;
    best_slot_r  <= best_slot_nxt;
    best_score_r <= best_score_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    out_score_r  <= out_score_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {4'd0, out_score_r, 4'(out_slot_r)};

endmodule

// ===== rtl/irpm_checker.sv =====
// Port-level checker for the pulse template matcher and its bind.
`include "assert_macros.svh"

module irpm_checker import irpm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result keeps its transaction and its payload.
  `IRPM_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A reported match always carries a positive score.
  `IRPM_ASSERT(a_score_pos, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[19:4] != 16'd0, "match with zero score")

  // Without a match the slot and score read as zero.
  `IRPM_ASSERT(a_nomatch_zero, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata == 24'd0, "no match but nonzero data")

  // Loads and ignored items leave the input open for the next transaction.
  `IRPM_ASSERT(a_load_ready, clk, rst_n, in_tvalid && in_tready && in_tuser != MODE_PULSE |=> in_tready, "input stalled after a load")

  // Reset empties the output register.
  `IRPM_ASSERT_NR(a_reset_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind ir_pulse_template_matcher_top irpm_checker u_irpm_checker (.*);

// ===== tb/sv/ir_pulse_template_matcher_top_tb.sv =====
// Self-checking testbench of the pulse template matcher: random loads and trains against a local predictor.
module ir_pulse_template_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irpm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int IDLE_PCT     = 32;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEM_GOAL    = 1700;
  localparam int PHASES       = 7;
  localparam int SETTLE_LIMIT = 200000;
  localparam int unsigned CORNER_WORDS [6] = '{0, 65535, 'h5555, 'hAAAA, 1000, 2000};

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [3:0]        slot;
    logic [5:0]        pos;
    logic [15:0]       word;
    logic [6:0]        len;
    logic [15:0]       pulse;
    logic              last;
  } pulse_item_t;

  typedef struct {
    logic        found;
    logic [3:0]  slot;
    logic [15:0] score;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  ir_pulse_template_matcher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state, updated on every accepted input transaction.
  dur_t             tpl_word [TEMPLATES][MAX_PULSES];
  len_t             tpl_len  [TEMPLATES];
  sum_t             diff_sum [TEMPLATES];
  len_t             seen_count;
  logic [TOL_W-1:0] tol_reg;
  len_t             minp_reg;
  verdict_t         verdicts_due [$];

  // Stimulus-side view of the templates, used to aim trains and to keep
  // every length within the words already written.
  int unsigned plan_word    [TEMPLATES][MAX_PULSES];
  bit          plan_written [TEMPLATES][MAX_PULSES];
  int          plan_prefix  [TEMPLATES];
  int          plan_len     [TEMPLATES];
  pulse_item_t pending_items [$];

  int items_made = 0;
  int trains_made = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int fail_count = 0;

  bit steady = 1'b0;
  bit stall_req = 1'b0;
  bit stall_done = 1'b0;
  int hold_left = 0;
  pulse_item_t drive_item;
  verdict_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void absorb_item(logic [1:0] mode, logic [55:0] d, logic is_last);
    logic [3:0] slot;
    logic [5:0] pos;
    dur_t       word;
    len_t       len;
    dur_t       pulse;
    int         t, gap, total, overlap, best, best_slot;
    verdict_t   v;
    slot = d[3:0];
    pos = d[9:4];
    word = d[25:10];
    len = d[32:26];
    pulse = d[48:33];
    best = 0;
    best_slot = 0;
    case (mode)
      MODE_WORD: tpl_word[slot][pos] = word;
      MODE_LEN: tpl_len[slot] = (len > MAX_PULSES) ? len_t'(MAX_PULSES) : len;
      MODE_PULSE: begin
        // Pulses past the deepest template position only end the train.
        if (seen_count < MAX_PULSES) begin
          for (t = 0; t < TEMPLATES; t++) begin
            if (seen_count < tpl_len[t]) begin
              gap = int'(pulse) - int'(tpl_word[t][seen_count]);
              if (gap < 0) gap = -gap;
              total = int'(diff_sum[t]) + gap;
              diff_sum[t] = (total > int'(SUM_MAX)) ? SUM_MAX : sum_t'(total);
            end
          end
          seen_count++;
        end
        if (is_last) begin
          if (seen_count >= minp_reg) begin
            for (t = 0; t < TEMPLATES; t++) begin
              overlap = (int'(seen_count) < int'(tpl_len[t])) ? int'(seen_count) : int'(tpl_len[t]);
              if (tpl_len[t] != 0 && int'(diff_sum[t]) <= overlap * int'(tol_reg) &&
                  int'(diff_sum[t]) < int'(SCORE_TOP) &&
                  int'(SCORE_TOP) - int'(diff_sum[t]) > best) begin
                best = int'(SCORE_TOP) - int'(diff_sum[t]);
                best_slot = t;
              end
            end
          end
          v.found = (best > 0);
          v.slot = 4'(best_slot);
          v.score = 16'(best);
          verdicts_due.push_back(v);
          for (t = 0; t < TEMPLATES; t++) diff_sum[t] = '0;
          seen_count = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_result();
    if (verdicts_due.size() == 0) begin
      $error("result with no train end pending: found=%0b slot=%0d score=%0d",
             out_tuser, out_tdata[3:0], out_tdata[19:4]);
      fail_count++;
    end else begin
      want = verdicts_due.pop_front();
      results_seen++;
      if (want.found) matches_seen++;
      if (out_tuser !== want.found) begin
        $error("match_found: expected %0b, actual %0b", want.found, out_tuser);
        fail_count++;
      end
      if (out_tdata[3:0] !== want.slot) begin
        $error("matched_slot: expected %0d, actual %0d", want.slot, out_tdata[3:0]);
        fail_count++;
      end
      if (out_tdata[19:4] !== want.score) begin
        $error("match_score: expected %0d, actual %0d", want.score, out_tdata[19:4]);
        fail_count++;
      end
    end
  endfunction

  function automatic pulse_item_t scrambled_item();
    pulse_item_t it;
    it.mode = MODE_PULSE;
    it.slot = 4'($urandom);
    it.pos = 6'($urandom);
    it.word = 16'($urandom);
    it.len = 7'($urandom);
    it.pulse = 16'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  function automatic void queue_word(int slot, int pos, int unsigned word);
    pulse_item_t it;
    it = scrambled_item();
    it.mode = MODE_WORD;
    it.slot = 4'(slot);
    it.pos = 6'(pos);
    it.word = 16'(word);
    plan_word[slot][pos] = word;
    plan_written[slot][pos] = 1'b1;
    while (plan_prefix[slot] < MAX_PULSES && plan_written[slot][plan_prefix[slot]])
      plan_prefix[slot]++;
    pending_items.push_back(it);
    items_made++;
  endfunction

  // The caller keeps len within the written prefix, or full, so no
  // unwritten word is ever compared.
  function automatic void queue_len(int slot, int len);
    pulse_item_t it;
    it = scrambled_item();
    it.mode = MODE_LEN;
    it.slot = 4'(slot);
    it.len = 7'(len);
    plan_len[slot] = (len > MAX_PULSES) ? MAX_PULSES : len;
    pending_items.push_back(it);
    items_made++;
  endfunction

  function automatic void queue_pulse(int pulse, bit is_last);
    pulse_item_t it;
    it = scrambled_item();
    it.mode = MODE_PULSE;
    it.pulse = 16'(pulse);
    it.last = is_last;
    pending_items.push_back(it);
    items_made++;
  endfunction

  function automatic void queue_ignored();
    pulse_item_t it;
    it = scrambled_item();
    it.mode = MODE_IGNORED;
    pending_items.push_back(it);
  endfunction

  // Slot -1 aims at nothing. A far train sends the complement of each word,
  // which drives the sums into saturation.
  function automatic void queue_train(int slot, int n, int amp, bit far);
    int i, base, p;
    for (i = 0; i < n; i++) begin
      if (slot >= 0 && i < plan_len[slot]) base = int'(plan_word[slot][i]);
      else base = int'($urandom_range(0, 65535));
      if (far) begin
        p = base ^ 'hFFFF;
      end else begin
        p = base + int'($urandom_range(0, 2 * amp)) - amp;
        if (p < 0) p = 0;
        else if (p > 65535) p = 65535;
      end
      queue_pulse(p, i == n - 1);
    end
    trains_made++;
  endfunction

  function automatic int pick_loaded_slot();
    int count, k, s;
    count = 0;
    for (s = 0; s < TEMPLATES; s++) if (plan_len[s] != 0) count++;
    if (count == 0) return -1;
    k = $urandom_range(0, count - 1);
    for (s = 0; s < TEMPLATES; s++) begin
      if (plan_len[s] != 0) begin
        if (k == 0) return s;
        k--;
      end
    end
    return -1;
  endfunction

  function automatic void random_action(int tol);
    int pick, slot, n, amp, base_len, choice, cap;
    bit far;
    pick = $urandom_range(0, 99);
    far = 1'b0;
    amp = 0;
    if (pick < 22) begin
      slot = $urandom_range(0, TEMPLATES - 1);
      // Half the time grow the lowest template that is not yet full.
      if ($urandom_range(0, 1) == 0) begin
        slot = 0;
        while (slot < TEMPLATES - 1 && plan_prefix[slot] == MAX_PULSES) slot++;
      end
      if (plan_prefix[slot] < MAX_PULSES && $urandom_range(0, 9) != 0)
        queue_word(slot, plan_prefix[slot], $urandom_range(0, 65535));
      else
        queue_word(slot, $urandom_range(0, MAX_PULSES - 1), $urandom_range(0, 65535));
    end else if (pick < 30) begin
      slot = $urandom_range(0, TEMPLATES - 1);
      choice = $urandom_range(0, 9);
      cap = (plan_prefix[slot] < 12) ? plan_prefix[slot] : 12;
      if (plan_prefix[slot] == MAX_PULSES && choice == 0)
        queue_len(slot, $urandom_range(MAX_PULSES, 127));
      else if (choice == 1 || plan_prefix[slot] == 0)
        queue_len(slot, 0);
      else if (choice < 4)
        queue_len(slot, $urandom_range(1, plan_prefix[slot]));
      else
        queue_len(slot, $urandom_range(1, cap));
    end else if (pick < 88) begin
      slot = pick_loaded_slot();
      base_len = (slot >= 0) ? plan_len[slot] : $urandom_range(1, 8);
      choice = $urandom_range(0, 19);
      if (choice < 13) n = base_len;
      else if (choice < 17) n = base_len + $urandom_range(0, 8) - 4;
      else if (choice < 19) n = $urandom_range(1, 3);
      else n = $urandom_range(MAX_PULSES + 1, MAX_PULSES + 6);
      if (n < 1) n = 1;
      choice = $urandom_range(0, 9);
      if (choice < 3) amp = 0;
      else if (choice < 7) amp = $urandom_range(0, tol);
      else if (choice < 9) amp = $urandom_range(0, 3 * tol + 20);
      else far = 1'b1;
      queue_train(slot, n, amp, far);
    end else if (pick < 93) begin
      queue_ignored();
    end else begin
      queue_pulse($urandom_range(0, 65535), $urandom_range(0, 3) == 0);
    end
  endfunction

  task automatic write_reg(logic idx, logic [9:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOLERANCE) tol_reg = value;
    else minp_reg = value[LEN_W-1:0];
    @(negedge clk);
  endtask

  // Waits until every queued transaction is taken and every result is back,
  // then lets a load still in flight finish.
  task automatic settle();
    int guard;
    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while ((pending_items.size() != 0 || in_tvalid || verdicts_due.size() != 0) &&
               guard < SETTLE_LIMIT);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        drive_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, drive_item.pulse, drive_item.len, drive_item.word,
                     drive_item.pos, drive_item.slot};
        in_tuser <= drive_item.mode;
        in_tlast <= drive_item.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) absorb_item(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) compare_result();
    end
  end

  initial begin
    int i, p, s, goal;
    logic [9:0] tol_set;
    logic [9:0] minp_set;
    tol_reg = TOL_RESET;
    minp_reg = MINP_RESET;
    seen_count = '0;
    for (s = 0; s < TEMPLATES; s++) begin
      tpl_len[s] = '0;
      diff_sum[s] = '0;
      plan_prefix[s] = 0;
      plan_len[s] = 0;
      for (i = 0; i < MAX_PULSES; i++) begin
        tpl_word[s][i] = '0;
        plan_word[s][i] = 0;
        plan_written[s][i] = 1'b0;
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset register values.
    queue_train(-1, 2, 0, 1'b0);
    queue_ignored();
    for (i = 0; i < 6; i++) queue_word(0, i, CORNER_WORDS[i]);
    queue_len(0, 6);
    for (i = 0; i < 6; i++) queue_word(TEMPLATES - 1, i, CORNER_WORDS[i]);
    queue_len(TEMPLATES - 1, 6);
    // Both templates score the same; the lower slot has to win.
    queue_train(0, 6, 0, 1'b0);
    // Shorter than the minimum pulse count.
    queue_train(0, 3, 0, 1'b0);
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tol_set = 10'd100; minp_set = 10'd5; end
        1: begin tol_set = 10'd0; minp_set = 10'd0; end
        2: begin tol_set = 10'd1023; minp_set = 10'd64; end
        4: begin tol_set = 10'd1; minp_set = 10'd1; end
        5: begin tol_set = 10'd512; minp_set = 10'd3; end
        default: begin
          tol_set = 10'($urandom_range(0, 1023));
          minp_set = 10'($urandom_range(0, 64));
        end
      endcase
      write_reg(CFG_TOLERANCE, tol_set);
      write_reg(CFG_MIN_PULSES, minp_set);
      steady = (p == 4);
      // The long output stall lands in the middle of a busy phase.
      if (p == 3) stall_req = 1'b1;
      goal = ITEM_GOAL * (p + 1) / PHASES;
      while (items_made < goal) random_action(int'(tol_reg));
      settle();
    end

    while (verdicts_due.size() != 0) begin
      want = verdicts_due.pop_front();
      $error("train end never answered: found=%0b slot=%0d score=%0d",
             want.found, want.slot, want.score);
      fail_count++;
    end
    $display("Ran %0d input transactions in %0d aimed trains; %0d results checked, %0d matched.",
             items_made, trains_made, results_seen, matches_seen);
    $display("Settings spanned tolerance 0 to 1023 and minimum count 0 to 64, with one long stall.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
